// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the search core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/ppr_pkg.sv =====
// Types and constants of the PLL power-of-two ratio search.
package ppr_pkg;

  localparam int FreqBitsDefault = 16;
  localparam int PllBitsDefault  = 10;
  localparam int OfsW            = 8;

  localparam int PllMinReset = 180;
  localparam int PllMaxReset = 360;
  localparam int OfsMaxReset = 7;

  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PLL_MIN = 2'd0,
    REG_PLL_MAX = 2'd1,
    REG_OFS_MAX = 2'd2
  } ppr_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } ppr_state_e;

endpackage

// ===== rtl/core/ppr_match.sv =====
// Combinational test of one candidate frequency against the PLL range.
module ppr_match import ppr_pkg::*; #(
  parameter int FREQ_BITS = FreqBitsDefault,
  parameter int PLL_BITS  = PllBitsDefault
) (
  input  logic [FREQ_BITS:0]  freq_i,
  input  logic [PLL_BITS-1:0] pll_min_i,
  input  logic [PLL_BITS-1:0] pll_max_i,
  output logic                hit_o,
  output logic [PLL_BITS-1:0] pll_o
);

  localparam int TzW = $clog2(FREQ_BITS + 1);

  logic [TzW-1:0]      tz;
  logic [FREQ_BITS:0]  odd;
  logic                fits;
  logic [2*PLL_BITS-1:0] cand;
  logic [2*PLL_BITS-1:0] min_ext;
  logic [2*PLL_BITS-1:0] max_ext;

  // Strip trailing zeros: every reachable PLL value is the odd part
  // shifted left by some amount.
  always_comb begin
    tz = '0;
    for (int i = FREQ_BITS; i >= 0; i--) begin
      if (freq_i[i]) begin
        tz = TzW'(i);
      end
    end
  end

  assign odd  = freq_i >> tz;
  assign fits = (freq_i != '0) && ((odd >> PLL_BITS) == '0);

  assign min_ext = {{PLL_BITS{1'b0}}, pll_min_i};
  assign max_ext = {{PLL_BITS{1'b0}}, pll_max_i};

  // Shifted copies grow with the shift, so the smallest shift in range
  // is the smallest matching PLL value.
  always_comb begin
    hit_o = 1'b0;
    pll_o = '0;
    cand  = '0;
    for (int j = PLL_BITS - 1; j >= 0; j--) begin
      cand = {{PLL_BITS{1'b0}}, odd[PLL_BITS-1:0]} << j;
      if (fits && cand >= min_ext && cand <= max_ext) begin
        hit_o = 1'b1;
        pll_o = cand[PLL_BITS-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/pll_power_of_two_ratio_search_core.sv =====
// Top level of the PLL power-of-two ratio search.
//
// A request carries a wanted frequency on requested_freq_i (valid/ready).
// The block tries candidate frequencies in order: the request, then for
// each offset d up to offset_max the request plus d, then the request
// minus d when the request exceeds d. Each candidate is tested by a shared
// match unit that finds the smallest PLL value in [pll_min, pll_max] whose
// ratio to the candidate is a power of two. The first hit ends the search;
// found_o low with zero fields means none. At most 2 * offset_max + 1
// candidates are tried. One request is in flight at a time: in_ready_o is
// high only while idle, so with a ready receiver a request passes through
// the search, response and idle states. After a response is taken the next
// request can be accepted in the following cycle. The response is held in
// registers until out_ready_i; a stalled receiver simply keeps the block
// waiting. Reset sets pll_min to 180, pll_max to 360 and offset_max to 7 and
// returns to idle. Register writes through cfg_we_i take effect at once; the
// user must keep them to idle periods, as the block does not enforce it.
module pll_power_of_two_ratio_search_core import ppr_pkg::*; #(
  parameter int FREQ_BITS = FreqBitsDefault,
  parameter int PLL_BITS  = PllBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [(PLL_BITS > OfsW ? PLL_BITS : OfsW)-1:0] cfg_wdata_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [FREQ_BITS-1:0] requested_freq_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_o,
  output logic [PLL_BITS-1:0]  pll_value_o,
  output logic [FREQ_BITS:0]   adjusted_freq_o
);

  ppr_state_e state_q, state_d;

  logic [PLL_BITS-1:0]  pll_min_q, pll_max_q;
  logic [OfsW-1:0]      ofs_max_q;

  logic [FREQ_BITS-1:0] req_q, req_d;
  logic [OfsW-1:0]      d_q, d_d;
  logic                 side_q, side_d;
  logic                 found_q, found_d;
  logic [PLL_BITS-1:0]  pll_q, pll_d;
  logic [FREQ_BITS:0]   adj_q, adj_d;

  logic [FREQ_BITS:0]   cand_freq;
  logic                 hit;
  logic [PLL_BITS-1:0]  hit_pll;
  logic                 minus_next;
  logic                 exhausted;
  logic                 in_fire;
  logic                 out_fire;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pll_min_q <= PLL_BITS'(PllMinReset);
      pll_max_q <= PLL_BITS'(PllMaxReset);
      ofs_max_q <= OfsW'(OfsMaxReset);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PLL_MIN: pll_min_q <= cfg_wdata_i[PLL_BITS-1:0];
        REG_PLL_MAX: pll_max_q <= cfg_wdata_i[PLL_BITS-1:0];
        REG_OFS_MAX: ofs_max_q <= cfg_wdata_i[OfsW-1:0];
        default: ;
      endcase
    end
  end

  // Candidate under test: request plus or minus the current offset.
  assign cand_freq = side_q ? ({1'b0, req_q} - (FREQ_BITS+1)'(d_q))
                            : ({1'b0, req_q} + (FREQ_BITS+1)'(d_q));

  ppr_match #(
    .FREQ_BITS (FREQ_BITS),
    .PLL_BITS  (PLL_BITS)
  ) u_match (
    .freq_i    (cand_freq),
    .pll_min_i (pll_min_q),
    .pll_max_i (pll_max_q),
    .hit_o     (hit),
    .pll_o     (hit_pll)
  );

  assign minus_next = !side_q && (d_q != '0) && (req_q > FREQ_BITS'(d_q));
  assign exhausted  = !minus_next && (d_q == ofs_max_q);

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SEARCH;
      ST_SEARCH: if (hit || exhausted) state_d = ST_DONE;
      ST_DONE:   if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o  = 1'b1;
      ST_SEARCH: ;
      ST_DONE:   out_valid_o = 1'b1;
      default:   ;
    endcase
  end

  // Search sequencer datapath.
  always_comb begin
    req_d   = req_q;
    d_d     = d_q;
    side_d  = side_q;
    found_d = found_q;
    pll_d   = pll_q;
    adj_d   = adj_q;
    if (in_fire) begin
      req_d  = requested_freq_i;
      d_d    = '0;
      side_d = 1'b0;
    end else if (state_q == ST_SEARCH) begin
      if (hit) begin
        found_d = 1'b1;
        pll_d   = hit_pll;
        adj_d   = cand_freq;
      end else if (exhausted) begin
        found_d = 1'b0;
        pll_d   = '0;
        adj_d   = '0;
      end else if (minus_next) begin
        side_d = 1'b1;
      end else begin
        side_d = 1'b0;
        d_d    = d_q + OfsW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      side_q  <= 1'b0;
      d_q     <= '0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
      d_q     <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    found_q <= found_d;
    pll_q   <= pll_d;
    adj_q   <= adj_d;
  end

  assign found_o         = found_q;
  assign pll_value_o     = pll_q;
  assign adjusted_freq_o = adj_q;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_ready_valid_excl, !(in_ready_o && out_valid_o), "ready while holding a response")
  `ASSERT_RST(a_minus_needs_offset, (state_q == ST_SEARCH && side_q) |-> (d_q != '0 && req_q > FREQ_BITS'(d_q)), "minus side with no room")
  `ASSERT_RST(a_miss_is_zero, (out_valid_o && !found_o) |-> (pll_value_o == '0 && adjusted_freq_o == '0), "miss with nonzero fields")
  `ASSERT_RST(a_hit_in_range, (out_valid_o && found_o) |-> (pll_value_o >= pll_min_q && pll_value_o <= pll_max_q && pll_value_o != '0), "hit outside PLL range")
  `ASSERT_RST(a_done_to_idle, out_fire |=> in_ready_o, "not idle after response taken")

endmodule
